// ----- rtl/core/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// grc_pkg
// shared types and constants of the graph reachability check block
// ----------------------------------------------------------------------------
package grc_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int NODE_W           = 6;
   localparam int OP_W             = 2;
   localparam int VCOUNT_W         = 7;

   // request opcodes, code 3 is unused
   localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY    = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

   // status codes
   localparam logic ST_OK    = 1'b0;
   localparam logic ST_RANGE = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] src_node;
      logic [NODE_W-1:0] dst_node;
   } grc_req_type;

   typedef struct packed {
      logic reachable;
      logic status;
   } grc_rsp_type;

   // adjacency store controls
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_all;
   } grc_adj_ctl_type;

   // node stack controls
   typedef struct packed {
      logic init;
      logic push;
      logic pop;
   } grc_stk_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EDGE_WR,
      S_EXPAND,
      S_PUSH,
      S_POP,
      S_REPLY
   } grc_state_type;

endpackage

// ----- rtl/core/grc_adj_store.sv -----
// ----------------------------------------------------------------------------
// grc_adj_store
// adjacency bit matrix, one row per vertex, with per-row valid bits
// ----------------------------------------------------------------------------
module grc_adj_store #(
   parameter int NV = grc_pkg::MAX_VERTICES_DEF,
   parameter int AW = $clog2(grc_pkg::MAX_VERTICES_DEF)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  grc_pkg::grc_adj_ctl_type  ctl,
   input  logic [AW-1:0]             rd_addr,
   input  logic [AW-1:0]             wr_addr,
   input  logic [NV-1:0]             wr_data,
   output logic [NV-1:0]             rd_row
);

   logic [NV-1:0] mem [NV];
   logic [NV-1:0] rd_data_ff;
   logic          rd_vld_ff;
   logic          rd_vld_in;
   logic [NV-1:0] row_valid_ff;
   logic [NV-1:0] row_valid_in;

   // a row never written since reset or clear reads as empty
   always_comb begin
      row_valid_in = row_valid_ff;
      if (ctl.clr_all) begin
         row_valid_in = '0;
      end else if (ctl.wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
      rd_vld_in = ctl.rd_en ? row_valid_ff[rd_addr] : rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/core/grc_stack.sv -----
// ----------------------------------------------------------------------------
// grc_stack
// node stack for the depth-first search, registered pop data
// ----------------------------------------------------------------------------
module grc_stack #(
   parameter int DEPTH = grc_pkg::MAX_VERTICES_DEF,
   parameter int DW    = $clog2(grc_pkg::MAX_VERTICES_DEF)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  grc_pkg::grc_stk_ctl_type  ctl,
   input  logic [DW-1:0]             push_data,
   output logic [DW-1:0]             pop_data,
   output logic                      empty
);

   localparam int AW  = $clog2(DEPTH);
   localparam int SPW = $clog2(DEPTH + 1);

   logic [DW-1:0]  mem [DEPTH];
   logic [DW-1:0]  pop_data_ff;
   logic [SPW-1:0] sp_ff;
   logic [SPW-1:0] sp_in;
   logic [SPW-1:0] sp_dec;

   assign sp_dec = sp_ff - SPW'(1);

   always_comb begin
      sp_in = sp_ff;
      if (ctl.init) begin
         sp_in = '0;
      end else if (ctl.push) begin
         sp_in = sp_ff + SPW'(1);
      end else if (ctl.pop) begin
         sp_in = sp_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[sp_ff[AW-1:0]] <= push_data;
      end
      if (ctl.pop) begin
         pop_data_ff <= mem[sp_dec[AW-1:0]];
      end
   end

   assign pop_data = pop_data_ff;
   assign empty    = (sp_ff == '0);

endmodule

// ----- rtl/core/graph_reachability_check.sv -----
// ----------------------------------------------------------------------------
// graph_reachability_check
// directed graph store with depth-first reachability queries
// ----------------------------------------------------------------------------
// the block holds a directed adjacency bit matrix in a row-wide memory with
// one valid flop per row, so reset and a clear request empty it with no
// clearing pass. an add-edge request takes a read and a write of one row. a
// query reads the source row first and answers at once on a direct edge;
// otherwise it runs a depth-first search: each reached vertex costs one row
// read (expand) and one stack pop, plus one push per newly found child onto
// the node stack, so a query is bounded by the single read port of the
// adjacency memory and the one-push-per-cycle node stack. a clear request or
// an unused opcode gives no response. add-edge and query requests naming a
// vertex at or beyond vertex_count get a response with status set and change
// nothing. the block works on one request at a time; a finished response
// waits in the output register while the next request is already being
// taken. vertex_count is written through the csr port, which is always
// ready; the user must write it only while the block is idle, as the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module graph_reachability_check #(
   parameter int MAX_VERTICES = grc_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  grc_pkg::grc_req_type          req_payload,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output grc_pkg::grc_rsp_type          rsp_payload,
   // configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [grc_pkg::VCOUNT_W-1:0]  csr_data
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam logic [MAX_VERTICES-1:0] VONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

   // control state
   grc_pkg::grc_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [grc_pkg::VCOUNT_W-1:0] vcount_ff, vcount_in;

   // payload registers
   logic [grc_pkg::NODE_W-1:0] src_ff, src_in;
   logic [grc_pkg::NODE_W-1:0] dst_ff, dst_in;
   logic [MAX_VERTICES-1:0]    visited_ff, visited_in;
   logic [MAX_VERTICES-1:0]    pend_ff, pend_in;
   logic                       reach_ff, reach_in;
   logic                       status_ff, status_in;
   grc_pkg::grc_rsp_type       rsp_data_ff, rsp_data_in;

   // datapath
   logic                       req_accept;
   logic                       in_range;
   logic [MAX_VERTICES-1:0]    active_mask;
   logic [MAX_VERTICES-1:0]    pend_low;
   logic [VW-1:0]              pend_idx;
   logic [VW-1:0]              dst_idx;
   logic [MAX_VERTICES-1:0]    children;

   // adjacency store and stack hookup
   grc_pkg::grc_adj_ctl_type   adj_ctl;
   logic [VW-1:0]              adj_rd_addr;
   logic [VW-1:0]              adj_wr_addr;
   logic [MAX_VERTICES-1:0]    adj_wr_data;
   logic [MAX_VERTICES-1:0]    adj_row;
   grc_pkg::grc_stk_ctl_type   stk_ctl;
   logic [VW-1:0]              stk_pop_data;
   logic                       stk_empty;

   grc_adj_store #(
      .NV (MAX_VERTICES),
      .AW (VW)
   ) u_adj_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (adj_ctl),
      .rd_addr (adj_rd_addr),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_row  (adj_row)
   );

   grc_stack #(
      .DEPTH (MAX_VERTICES),
      .DW    (VW)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stk_ctl),
      .push_data (pend_idx),
      .pop_data  (stk_pop_data),
      .empty     (stk_empty)
   );

   // handshakes
   assign req_stall   = (state_ff != grc_pkg::S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign vcount_in = (csr_valid && csr_ready) ? csr_data : vcount_ff;

   // both indices must lie below the vertex count and the store size
   assign in_range = ({1'b0, req_payload.src_node} < vcount_ff)
                  && ({1'b0, req_payload.dst_node} < vcount_ff)
                  && (int'(req_payload.src_node) < MAX_VERTICES)
                  && (int'(req_payload.dst_node) < MAX_VERTICES);

   // vertices in use
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         active_mask[i] = (i < int'(vcount_ff));
      end
   end

   // lowest pending child, isolated then encoded
   assign pend_low = pend_ff & (~pend_ff + VONE);

   always_comb begin
      pend_idx = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (pend_low[i]) begin
            pend_idx = pend_idx | VW'(i);
         end
      end
   end

   assign dst_idx  = VW'(dst_ff);
   // unvisited successors of the row just read
   assign children = adj_row & ~visited_ff & active_mask;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      visited_in   = visited_ff;
      pend_in      = pend_ff;
      reach_in     = reach_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      adj_ctl      = '0;
      adj_rd_addr  = VW'(req_payload.src_node);
      adj_wr_addr  = VW'(src_ff);
      adj_wr_data  = adj_row | (VONE << dst_idx);
      stk_ctl      = '0;

      unique case (state_ff)
         grc_pkg::S_IDLE: begin
            if (req_accept) begin
               src_in = req_payload.src_node;
               dst_in = req_payload.dst_node;
               unique case (req_payload.op) inside
                  grc_pkg::OP_ADD_EDGE,
                  grc_pkg::OP_QUERY: begin
                     if (!in_range) begin
                        reach_in  = 1'b0;
                        status_in = grc_pkg::ST_RANGE;
                        state_in  = grc_pkg::S_REPLY;
                     end else if (req_payload.op == grc_pkg::OP_ADD_EDGE) begin
                        // fetch the row to merge the new edge into
                        adj_ctl.rd_en = 1'b1;
                        state_in      = grc_pkg::S_EDGE_WR;
                     end else begin
                        // source row first, source marked visited
                        adj_ctl.rd_en = 1'b1;
                        stk_ctl.init  = 1'b1;
                        visited_in    = VONE << VW'(req_payload.src_node);
                        state_in      = grc_pkg::S_EXPAND;
                     end
                  end
                  grc_pkg::OP_CLEAR: begin
                     adj_ctl.clr_all = 1'b1;
                  end
                  default: begin
                     // unused opcode, dropped
                  end
               endcase
            end
         end

         grc_pkg::S_EDGE_WR: begin
            adj_ctl.wr_en = 1'b1;
            reach_in      = 1'b0;
            status_in     = grc_pkg::ST_OK;
            state_in      = grc_pkg::S_REPLY;
         end

         grc_pkg::S_EXPAND: begin
            // a path exists once any reached vertex has an edge to dst
            if (adj_row[dst_idx]) begin
               reach_in  = 1'b1;
               status_in = grc_pkg::ST_OK;
               state_in  = grc_pkg::S_REPLY;
            end else begin
               pend_in    = children;
               visited_in = visited_ff | children;
               state_in   = grc_pkg::S_PUSH;
            end
         end

         grc_pkg::S_PUSH: begin
            if (pend_ff != '0) begin
               stk_ctl.push = 1'b1;
               pend_in      = pend_ff & ~pend_low;
            end else if (stk_empty) begin
               // search exhausted
               reach_in  = 1'b0;
               status_in = grc_pkg::ST_OK;
               state_in  = grc_pkg::S_REPLY;
            end else begin
               stk_ctl.pop = 1'b1;
               state_in    = grc_pkg::S_POP;
            end
         end

         grc_pkg::S_POP: begin
            adj_ctl.rd_en = 1'b1;
            adj_rd_addr   = stk_pop_data;
            state_in      = grc_pkg::S_EXPAND;
         end

         grc_pkg::S_REPLY: begin
            // hand over once the output register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.reachable = reach_ff;
               rsp_data_in.status    = status_ff;
               state_in              = grc_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = grc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         vcount_ff    <= vcount_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      visited_ff  <= visited_in;
      pend_ff     <= pend_in;
      reach_ff    <= reach_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- verif/graph_reachability_check_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_reachability_check_tb
// self-checking bench for the graph reachability check block
// ----------------------------------------------------------------------------
// requests go in through the stall handshake and each accepted one updates a
// behavioural copy of the edge store, which also works out the response
// that should come back. responses are checked in order against that copy.
// a short directed run covers range errors, cycles, dead-end children and
// shrinking the vertex count, then random graph traffic runs under several
// vertex counts with random idling on both sides and a long output hold.
// ----------------------------------------------------------------------------
module graph_reachability_check_tb;

   // opcode the block has no use for
   localparam logic [grc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int REQUEST_TARGET = 1250;
   localparam int CLEAR_SETTLE   = 20;     // a clear or ignored request is short
   localparam int QUERY_SETTLE   = 300;    // worst search over 64 vertices
   localparam int CYCLE_LIMIT    = 2000000;
   localparam int REPORT_LIMIT   = 10;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   grc_pkg::grc_req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   grc_pkg::grc_rsp_type rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [grc_pkg::VCOUNT_W-1:0] csr_data = '0;

   // behavioural copy of the block state
   logic [63:0]  edge_rows [0:63];
   int unsigned  live_vertices = 0;

   grc_pkg::grc_rsp_type pending_answers [$];
   int           bad_answers = 0;
   int           request_count = 0;
   int           cycle_count = 0;
   int           hold_left = 0;
   bit           quiet_mode = 1'b0;

   graph_reachability_check uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   // true when a path of one or more edges leads from one vertex to another,
   // using only vertices below the live count
   function automatic bit path_exists(input int unsigned from_v, input int unsigned to_v);
      logic [63:0] live, seen, frontier, grown;
      live = (live_vertices >= 64) ? '1 : ((64'd1 << live_vertices) - 64'd1);
      seen = edge_rows[from_v] & live;
      frontier = seen;
      // widen the reached set until nothing new turns up
      while (frontier != '0) begin
         grown = '0;
         for (int v = 0; v < 64; v++)
            if (frontier[v]) grown |= edge_rows[v];
         grown &= live;
         frontier = grown & ~seen;
         seen |= grown;
      end
      return seen[to_v];
   endfunction

   // applies one request to the edge store, returns 1 when a response is due
   function automatic bit predict_answer(input grc_pkg::grc_req_type req,
                                         output grc_pkg::grc_rsp_type answer);
      answer = '0;
      case (req.op) inside
         grc_pkg::OP_CLEAR: begin
            foreach (edge_rows[i]) edge_rows[i] = '0;
            return 1'b0;
         end
         grc_pkg::OP_ADD_EDGE, grc_pkg::OP_QUERY: begin
            if (req.src_node >= live_vertices || req.dst_node >= live_vertices)
               answer.status = grc_pkg::ST_RANGE;
            else if (req.op == grc_pkg::OP_ADD_EDGE)
               edge_rows[req.src_node][req.dst_node] = 1'b1;
            else
               answer.reachable = path_exists(32'(req.src_node), 32'(req.dst_node));
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------

   // output stall: a counted hold, quiet stretches, otherwise random
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (quiet_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 21);
      end
   end

   // compare every accepted response with the oldest outstanding answer
   always @(posedge clock) begin
      grc_pkg::grc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            bad_answers++;
            if (bad_answers <= REPORT_LIMIT)
               $display("unexpected response reachable=%0b status=%0b",
                        rsp_payload.reachable, rsp_payload.status);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_payload.reachable !== want.reachable ||
                rsp_payload.status !== want.status) begin
               bad_answers++;
               if (bad_answers <= REPORT_LIMIT)
                  $display("response mismatch: reachable exp %0b got %0b, status exp %0b got %0b",
                           want.reachable, rsp_payload.reachable,
                           want.status, rsp_payload.status);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offers one request, holds it until taken, then records its answer;
   // valid stays high afterwards so back-to-back requests need no gap
   task automatic send_request(input logic [grc_pkg::OP_W-1:0] op, input int unsigned src,
                               input int unsigned dst);
      grc_pkg::grc_req_type req;
      grc_pkg::grc_rsp_type answer;
      req.op = op;
      req.src_node = grc_pkg::NODE_W'(src);
      req.dst_node = grc_pkg::NODE_W'(dst);
      @(negedge clock);
      while (!quiet_mode && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (req_stall);
      if (predict_answer(req, answer)) pending_answers.push_back(answer);
      if (op != OP_UNUSED) request_count++;
   endtask

   // drop valid and wait for every outstanding response, then let the block settle
   task automatic wait_drained(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_vertex_count(input int unsigned count);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= grc_pkg::VCOUNT_W'(count);
      do @(posedge clock); while (!csr_ready);
      live_vertices = (count > 64) ? 64 : count;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_directed_cases();
      // nothing is in range straight after reset
      send_request(grc_pkg::OP_QUERY, 0, 0);
      wait_drained(CLEAR_SETTLE);

      // single vertex with a self loop, and the neighbour out of range
      write_vertex_count(1);
      send_request(grc_pkg::OP_ADD_EDGE, 0, 0);
      send_request(grc_pkg::OP_QUERY, 0, 0);
      send_request(grc_pkg::OP_QUERY, 0, 1);
      wait_drained(CLEAR_SETTLE);

      // chain to the top vertex with a dead-end sibling that must be backed out of
      write_vertex_count(64);
      send_request(grc_pkg::OP_ADD_EDGE, 0, 1);
      send_request(grc_pkg::OP_ADD_EDGE, 0, 62);
      send_request(grc_pkg::OP_ADD_EDGE, 1, 2);
      send_request(grc_pkg::OP_ADD_EDGE, 2, 3);
      send_request(grc_pkg::OP_ADD_EDGE, 3, 63);
      send_request(grc_pkg::OP_QUERY, 0, 63);
      send_request(grc_pkg::OP_QUERY, 63, 0);
      // closing the loop makes every chain vertex reach itself
      send_request(grc_pkg::OP_ADD_EDGE, 63, 0);
      send_request(grc_pkg::OP_QUERY, 62, 62);
      send_request(grc_pkg::OP_QUERY, 1, 1);
      send_request(OP_UNUSED, 63, 63);
      wait_drained(CLEAR_SETTLE);

      // shrunk count: the edge through vertex 63 is kept but must not be used
      write_vertex_count(4);
      send_request(grc_pkg::OP_QUERY, 0, 2);
      send_request(grc_pkg::OP_QUERY, 3, 0);
      send_request(grc_pkg::OP_ADD_EDGE, 4, 0);
      send_request(grc_pkg::OP_QUERY, 0, 63);
      wait_drained(CLEAR_SETTLE);

      // counts above the vertex limit behave as the limit, old edges come back
      write_vertex_count(127);
      send_request(grc_pkg::OP_QUERY, 3, 0);
      send_request(grc_pkg::OP_CLEAR, 0, 0);
      send_request(grc_pkg::OP_QUERY, 0, 1);
      send_request(grc_pkg::OP_ADD_EDGE, 63, 63);
      send_request(grc_pkg::OP_QUERY, 63, 63);
   endtask

   // hold the output long enough that the block backs up onto its input,
   // then stop sending until everything has come back
   task automatic test_output_backpressure();
      wait_drained(CLEAR_SETTLE);
      write_vertex_count(16);
      hold_left = 400;
      send_request(grc_pkg::OP_CLEAR, 0, 0);
      repeat (40) begin
         if ($urandom_range(0, 1))
            send_request(grc_pkg::OP_ADD_EDGE, $urandom_range(0, 15),
                         $urandom_range(0, 15));
         else
            send_request(grc_pkg::OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15));
      end
      wait_drained(CLEAR_SETTLE);
   endtask

   // one vertex count, usually a fresh graph, then mostly well-formed traffic
   task automatic random_phase(input int unsigned count, input int len);
      int unsigned live, roll;
      wait_drained(CLEAR_SETTLE);
      write_vertex_count(count);
      live = (count > 64) ? 64 : count;
      if ($urandom_range(0, 3) != 0) send_request(grc_pkg::OP_CLEAR, 0, 0);
      repeat (len) begin
         roll = $urandom_range(0, 99);
         if (live == 0 || roll >= 92)
            // noise: any vertex pair, often out of range
            send_request($urandom_range(0, 1) ? grc_pkg::OP_QUERY : grc_pkg::OP_ADD_EDGE,
                         $urandom_range(0, 63), $urandom_range(0, 63));
         else if (roll < 45)
            send_request(grc_pkg::OP_ADD_EDGE, $urandom_range(0, live - 1),
                         $urandom_range(0, live - 1));
         else if (roll < 85)
            send_request(grc_pkg::OP_QUERY, $urandom_range(0, live - 1),
                         $urandom_range(0, live - 1));
         else if (roll < 88)
            send_request(grc_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
         else
            send_request(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
      end
   endtask

   task automatic test_random_traffic();
      int phase_no;
      int len;
      int unsigned count;
      phase_no = 0;
      while (request_count < REQUEST_TARGET) begin
         // most phases use small graphs, a few the full vertex range
         case (phase_no % 8)
            2:       count = 64;
            3:       count = $urandom_range(13, 63);
            5:       count = 127;
            6:       count = 0;
            7:       count = 1;
            default: count = $urandom_range(2, 12);
         endcase
         len = $urandom_range(20, 60);
         // one long stretch with no idling on either side
         if (phase_no == 4) begin
            wait_drained(CLEAR_SETTLE);
            quiet_mode = 1'b1;
            len = 150;
         end
         random_phase(count, len);
         if (phase_no == 4) begin
            wait_drained(CLEAR_SETTLE);
            quiet_mode = 1'b0;
         end
         phase_no++;
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      foreach (edge_rows[i]) edge_rows[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_output_backpressure();
      test_random_traffic();

      // all requests in, wait out the longest possible search
      wait_drained(QUERY_SETTLE);
      if (bad_answers == 0 && pending_answers.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
